// ===== hw/rtl/voice_priority_stack_defines.svh =====
// Assertion macros shared by the voice priority stack RTL.
// Depends on nothing; each user supplies its own clock and reset names.
`ifndef VOICE_PRIORITY_STACK_DEFINES_SVH
`define VOICE_PRIORITY_STACK_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define VPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice_priority_stack check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define VPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice_priority_stack check failed");

`endif

// ===== hw/rtl/vps_pkg.sv =====
// Shared types and constants for the voice priority stack.
// No dependencies; imported by vps_cell, voice_priority_stack and the test bench.
package vps_pkg;

   localparam int VOICES = 8;
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int IDX_W  = $clog2(VOICES);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] voice_index;
   } req_type;

   typedef struct packed {
      logic [7:0] active_voice;
      logic       active_valid;
      logic [3:0] voice_count;
      logic       done_ok;
   } rsp_type;

   typedef struct packed {
      logic       go;
      logic       opcode;
      logic [7:0] voice;
      logic       occupied;
      logic       at_tail;
      logic       shift_ok;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/voice_priority_stack.sv =====
// Top level of the last-note-priority voice stack.
// Depends on vps_pkg, vps_cell and voice_priority_stack_defines.svh.
//
//  channel | ports                             | carries
//  --------+-----------------------------------+------------------------------------
//  req     | req_valid, req_ready, req_payload | opcode, voice_index
//  rsp     | rsp_valid, rsp_ready, rsp_payload | active_voice, active_valid, count, ok
//
// Cycles: one beat per clock unless rsp stalls. A req beat updates the slot
// chain in the cycle it is accepted; its rsp beat is registered and shows the
// next cycle. The length of the match chain through the VOICES cells sets the cycle time.
// Reset: synchronous, active high; clears the held count and the rsp valid.
// Slot contents are not cleared; slots at or above the count are never read.
// Stalls: a req beat is taken when the rsp register is empty or being drained.
`include "voice_priority_stack_defines.svh"

module voice_priority_stack (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vps_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vps_pkg::rsp_type rsp_payload
);
   import vps_pkg::*;

   cell_ctl_type     ctl [VOICES];
   logic             hit [VOICES + 1];
   logic [7:0]       slot_q [VOICES];
   logic [7:0]       slot_next [VOICES];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] tail_pos;
   logic [IDX_W-1:0] tail_idx;
   logic             req_fire;
   logic             full;
   logic             found;
   logic             done_ok;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_payload_ff;
   rsp_type          rsp_payload_in;

   logic             grow_beat;
   logic             miss_beat;
   logic             rsp_empty;
   logic             rsp_quiet;

   // Accept a new beat whenever the result register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(VOICES));

   // Build the per-slot controls; slot i is occupied below the count.
   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         ctl[i].go       = req_fire;
         ctl[i].opcode   = req_payload.opcode;
         ctl[i].voice    = req_payload.voice_index;
         ctl[i].occupied = CNT_W'(i) < count_ff;
         ctl[i].at_tail  = CNT_W'(i) == count_ff;
         ctl[i].shift_ok = CNT_W'(i + 1) < count_ff;
      end
   end

   // Chain of slots: the hit flag ripples from the oldest slot upward and
   // each slot pulls its upper neighbor once a match has been seen at or below it.
   assign hit[0] = 1'b0;

   for (genvar g = 0; g < VOICES; g++) begin : g_cell
      logic [7:0] upper;
      if (g == VOICES - 1) begin : g_last
         assign upper = slot_q[g];
      end else begin : g_mid
         assign upper = slot_q[g + 1];
      end
      vps_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .hit_in     (hit[g]),
         .upper_slot (upper),
         .hit_out    (hit[g + 1]),
         .slot_q     (slot_q[g]),
         .slot_next  (slot_next[g])
      );
   end

   assign found = hit[VOICES];

   // Advance the count: grow on a stored add, shrink on a matched remove.
   always_comb begin
      count_in = count_ff;
      done_ok  = 1'b0;
      if (req_fire) begin
         unique case (req_payload.opcode)
            OP_ADD: begin
               done_ok = !full;
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               done_ok = found;
               if (found) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               done_ok = 1'b0;
            end
         endcase
      end
   end

   // Newest voice after the update sits at slot count - 1.
   assign tail_pos = count_in - CNT_W'(1);
   assign tail_idx = tail_pos[IDX_W-1:0];

   always_comb begin
      rsp_payload_in.active_valid = (count_in != '0);
      rsp_payload_in.active_voice = (count_in != '0) ? slot_next[tail_idx] : 8'd0;
      rsp_payload_in.voice_count  = 4'(count_in);
      rsp_payload_in.done_ok      = done_ok;
   end

   // Hold the result until taken; load a fresh one on every accepted beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Conditions watched by the checks below.
   assign grow_beat = req_fire && req_payload.opcode == OP_ADD && !full;
   assign miss_beat = req_fire && req_payload.opcode == OP_REMOVE && !found;
   assign rsp_empty = rsp_valid_ff && rsp_payload_ff.voice_count == 4'd0;
   assign rsp_quiet = !rsp_payload_ff.active_valid && rsp_payload_ff.active_voice == 8'd0;

   // The held count never passes the number of slots.
   `VPS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(VOICES))
   // An add into a list with room grows the count by one.
   `VPS_ASSERT_NEXT(a_add_grows, clock, reset, grow_beat, count_ff == $past(count_ff) + CNT_W'(1))
   // A remove that finds nothing leaves the count alone.
   `VPS_ASSERT_NEXT(a_miss_keeps, clock, reset, miss_beat, $stable(count_ff))
   // An empty list reports voice zero and no active voice.
   `VPS_ASSERT_NOW(a_empty_rsp, clock, reset, rsp_empty, rsp_quiet)

endmodule

// ===== hw/rtl/vps_cell.sv =====
// One slot of the voice stack: holds a voice index, compares it, shifts down.
// Depends on vps_pkg for the control struct.
module vps_cell (
   input  logic                  clock,
   input  vps_pkg::cell_ctl_type ctl,
   input  logic                  hit_in,
   input  logic [7:0]            upper_slot,
   output logic                  hit_out,
   output logic [7:0]            slot_q,
   output logic [7:0]            slot_next
);
   import vps_pkg::*;

   logic [7:0] slot_ff;
   logic [7:0] slot_in;
   logic       match;

   assign match   = ctl.occupied && (slot_ff == ctl.voice);
   assign hit_out = hit_in || match;

   always_comb begin
      slot_in = slot_ff;
      if (ctl.go) begin
         unique case (ctl.opcode)
            OP_ADD: begin
               // take the new voice when this is the first free slot
               if (ctl.at_tail) begin
                  slot_in = ctl.voice;
               end
            end
            OP_REMOVE: begin
               // close the gap at and above the oldest match
               if (hit_out && ctl.shift_ok) begin
                  slot_in = upper_slot;
               end
            end
            default: begin
               slot_in = slot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_q    = slot_ff;
   assign slot_next = slot_in;

endmodule

// ===== test/voice_priority_stack_test.sv =====
// Self-checking bench for voice_priority_stack: add and remove beats, per-beat reports.
// Depends on vps_pkg and the voice_priority_stack RTL; reads no files.
`timescale 1ns / 100ps

// Track the held voices and predict the report of every note beat.
class held_voice_tracker;
   logic [7:0]       slots [vps_pkg::VOICES];
   int unsigned      held;
   vps_pkg::rsp_type pending_reports [$];
   int unsigned      mismatches;
   int unsigned      adds;
   int unsigned      removes;
   int unsigned      full_rejects;
   int unsigned      missed_removes;
   int unsigned      reports_checked;

   function new();
      held            = 0;
      mismatches      = 0;
      adds            = 0;
      removes         = 0;
      full_rejects    = 0;
      missed_removes  = 0;
      reports_checked = 0;
   endfunction

   function int unsigned outstanding();
      return pending_reports.size();
   endfunction

   function logic [7:0] held_voice(int unsigned pos);
      return slots[pos];
   endfunction

   // Apply one accepted note beat to the stack and queue its report.
   function void record_note_event(vps_pkg::req_type beat);
      vps_pkg::rsp_type report;
      bit               ok;
      int unsigned      pos;
      int unsigned      k;
      ok = 1'b0;
      if (beat.opcode == vps_pkg::OP_ADD) begin
         adds++;
         if (held < vps_pkg::VOICES) begin
            slots[held] = beat.voice_index;
            held++;
            ok = 1'b1;
         end else begin
            full_rejects++;
         end
      end else begin
         removes++;
         pos = held;
         for (k = 0; k < held; k++) begin
            if (slots[k] == beat.voice_index) begin
               pos = k;
               break;
            end
         end
         if (pos < held) begin
            // close the gap, keeping the order of the rest
            for (k = pos; k + 1 < held; k++)
               slots[k] = slots[k + 1];
            held--;
            ok = 1'b1;
         end else begin
            missed_removes++;
         end
      end
      report.active_valid = (held != 0);
      report.active_voice = (held != 0) ? slots[held - 1] : 8'd0;
      report.voice_count  = 4'(held);
      report.done_ok      = ok;
      pending_reports.push_back(report);
   endfunction

   // Compare one accepted report beat with the oldest prediction.
   function void check_report(vps_pkg::rsp_type seen);
      vps_pkg::rsp_type want;
      if (pending_reports.size() == 0) begin
         $display("%0t: rsp beat with nothing expected, got %h", $time, seen);
         mismatches++;
         return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (seen.active_voice !== want.active_voice) begin
         $display("%0t: active_voice expected %0d, got %0d", $time,
                  want.active_voice, seen.active_voice);
         mismatches++;
      end
      if (seen.active_valid !== want.active_valid) begin
         $display("%0t: active_valid expected %0b, got %0b", $time,
                  want.active_valid, seen.active_valid);
         mismatches++;
      end
      if (seen.voice_count !== want.voice_count) begin
         $display("%0t: voice_count expected %0d, got %0d", $time,
                  want.voice_count, seen.voice_count);
         mismatches++;
      end
      if (seen.done_ok !== want.done_ok) begin
         $display("%0t: done_ok expected %0b, got %0b", $time,
                  want.done_ok, seen.done_ok);
         mismatches++;
      end
   endfunction
endclass

module voice_priority_stack_test;
   import vps_pkg::*;

   localparam int RANDOM_NOTES = 1750;
   localparam int BLOCK_NOTES  = 50;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   held_voice_tracker tracker = new();

   voice_priority_stack dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #10_000_000;
      $display("voice_priority_stack regression: fail");
      $finish;
   end

   // Sender gap: mostly none or short, now and then long. An eager block never idles.
   function int unsigned sender_gap(bit eager);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (eager || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   // Pick a voice index. Removes mostly hit a held entry so the stack compacts;
   // a small pool breeds duplicates, and full-range values cover every bit.
   function logic [7:0] pick_voice(bit removing);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (removing && tracker.held != 0 && r < 60)
         return tracker.held_voice($urandom_range(0, tracker.held - 1));
      if (r < 80)
         return 8'($urandom_range(0, 11));
      return 8'($urandom_range(0, 255));
   endfunction

   // Drive one note beat after an idle gap, hold it until accepted, then note it.
   task automatic send_note(input logic op, input logic [7:0] voice, input int unsigned gap);
      req_type beat;
      beat.opcode      = op;
      beat.voice_index = voice;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      do
         @(posedge clock);
      while (!req_ready);
      tracker.record_note_event(beat);
   endtask

   // Drop valid and hold off until every predicted report has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
   endtask

   // Receiver: runs of ready, most short, a few long with no stall at all,
   // broken by stalls that are most often absent, otherwise short and sometimes long.
   initial begin : rsp_backpressure
      int unsigned run;
      int unsigned stall;
      int unsigned r;
      rsp_ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
         r = $urandom_range(0, 99);
         stall = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
         repeat (run) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Check every rsp beat on the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_report(rsp_payload);
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned add_pct;
      int unsigned k;
      bit          eager;
      logic        op;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-stack remove, extremes, duplicates, fill to full,
      // add on a full stack, remove from the middle, the oldest and the newest,
      // remove with no match, then drain back to empty and remove once more.
      send_note(OP_REMOVE, 8'd5,   sender_gap(0));
      send_note(OP_ADD,    8'd0,   sender_gap(0));
      send_note(OP_ADD,    8'd255, sender_gap(0));
      send_note(OP_ADD,    8'd0,   sender_gap(0));
      send_note(OP_ADD,    8'd128, sender_gap(0));
      send_note(OP_ADD,    8'd1,   sender_gap(0));
      send_note(OP_ADD,    8'd254, sender_gap(0));
      send_note(OP_ADD,    8'd127, sender_gap(0));
      send_note(OP_ADD,    8'd64,  sender_gap(0));
      send_note(OP_ADD,    8'd200, sender_gap(0));
      send_note(OP_REMOVE, 8'd254, sender_gap(0));
      send_note(OP_REMOVE, 8'd0,   sender_gap(0));
      send_note(OP_REMOVE, 8'd64,  sender_gap(0));
      send_note(OP_REMOVE, 8'd77,  sender_gap(0));
      send_note(OP_ADD,    8'd85,  sender_gap(0));
      send_note(OP_ADD,    8'd170, sender_gap(0));
      send_note(OP_REMOVE, 8'd255, sender_gap(0));
      send_note(OP_REMOVE, 8'd0,   sender_gap(0));
      send_note(OP_REMOVE, 8'd128, sender_gap(0));
      send_note(OP_REMOVE, 8'd1,   sender_gap(0));
      send_note(OP_REMOVE, 8'd127, sender_gap(0));
      send_note(OP_REMOVE, 8'd85,  sender_gap(0));
      send_note(OP_REMOVE, 8'd170, sender_gap(0));
      send_note(OP_REMOVE, 8'd170, sender_gap(0));
      wait_drained();

      // Random blocks: most lean toward adds or removes so the depth swings
      // between empty and full; some blocks send back to back.
      sent = 0;
      while (sent < RANDOM_NOTES) begin
         case ($urandom_range(0, 3))
            0: add_pct = 25;
            1: add_pct = 50;
            2: add_pct = 75;
            default: add_pct = 90;
         endcase
         eager = ($urandom_range(0, 3) == 0);
         for (k = 0; k < BLOCK_NOTES && sent < RANDOM_NOTES; k++) begin
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
            send_note(op, pick_voice(op == OP_REMOVE), sender_gap(eager));
            sent++;
         end
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end

      wait_drained();
      // let any stray rsp beat show up
      repeat (8) @(posedge clock);

      $display("%0d note beats: %0d adds, %0d removes; %0d reports checked",
               tracker.adds + tracker.removes, tracker.adds, tracker.removes,
               tracker.reports_checked);
      $display("%0d adds refused on a full stack, %0d removes found no match",
               tracker.full_rejects, tracker.missed_removes);
      if (tracker.mismatches == 0) begin
         $display("voice_priority_stack regression: pass");
      end else begin
         $display("voice_priority_stack regression: fail");
      end
      $finish;
   end
endmodule
